/* rtl/mtk_pkg.sv */
// ----------------------------------------------------------------------------
// mtk_pkg: shared types and constants for the multi-tap keypad text entry
// key codes, letter table, press descriptor passed from front to back
// ----------------------------------------------------------------------------
package mtk_pkg;

   localparam int MSG_DEPTH_DEF = 64;
   localparam int KEY_W         = 12;
   localparam int TIME_W        = 32;
   localparam int CFG_W         = 16;
   localparam int CHAR_W        = 8;
   localparam int LEN_W         = 6;
   localparam int CSR_IDX_W     = 2;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [KEY_W-1:0] KEY_ABC    = 12'h7EF;
   localparam logic [KEY_W-1:0] KEY_DEF    = 12'hBEF;
   localparam logic [KEY_W-1:0] KEY_GHI    = 12'h3EF;
   localparam logic [KEY_W-1:0] KEY_JKL    = 12'hDEF;
   localparam logic [KEY_W-1:0] KEY_MNO    = 12'h5EF;
   localparam logic [KEY_W-1:0] KEY_PQRS   = 12'h9EF;
   localparam logic [KEY_W-1:0] KEY_TUV    = 12'h1EF;
   localparam logic [KEY_W-1:0] KEY_WXYZ   = 12'hEEF;
   localparam logic [KEY_W-1:0] KEY_SPACE  = 12'h6EF;
   localparam logic [KEY_W-1:0] KEY_CAPS   = 12'hFEF;
   localparam logic [KEY_W-1:0] KEY_DELETE = 12'h22F;
   localparam logic [KEY_W-1:0] KEY_SEND   = 12'hD6F;

   localparam logic [CFG_W-1:0] HOLDOFF_RST = 16'd200;
   localparam logic [CFG_W-1:0] TIMEOUT_RST = 16'd1500;

   localparam logic [CHAR_W-1:0] CASE_SHIFT = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

   localparam logic signed [3:0] CYCLE_MAX  = 4'sd7;
   localparam logic signed [3:0] CYCLE_NONE = -4'sd1;

   localparam logic [CSR_IDX_W-1:0] CSR_HOLDOFF = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 2'd1;

   typedef enum logic [2:0] {
      KC_LETTER,
      KC_SPACE,
      KC_CAPS,
      KC_DELETE,
      KC_SEND,
      KC_OTHER
   } key_class_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      key_class_type     kclass;
      logic [CHAR_W-1:0] base;
      logic              span4;
      logic              timed_out;
   } press_type;

   // decode a key into its class and letter group
   function automatic press_type classify(input logic [KEY_W-1:0] key);
      press_type p;
      p.key       = key;
      p.kclass    = KC_LETTER;
      p.base      = CHAR_NONE;
      p.span4     = 1'b0;
      p.timed_out = 1'b0;
      unique case (key)
         KEY_ABC:    p.base = 8'h61;
         KEY_DEF:    p.base = 8'h64;
         KEY_GHI:    p.base = 8'h67;
         KEY_JKL:    p.base = 8'h6A;
         KEY_MNO:    p.base = 8'h6D;
         KEY_PQRS: begin
            p.base  = 8'h70;
            p.span4 = 1'b1;
         end
         KEY_TUV:    p.base = 8'h74;
         KEY_WXYZ: begin
            p.base  = 8'h77;
            p.span4 = 1'b1;
         end
         KEY_SPACE:  p.kclass = KC_SPACE;
         KEY_CAPS:   p.kclass = KC_CAPS;
         KEY_DELETE: p.kclass = KC_DELETE;
         KEY_SEND:   p.kclass = KC_SEND;
         default:    p.kclass = KC_OTHER;
      endcase
      return p;
   endfunction

   // remainder by three of a repeat count 0..7
   function automatic logic [1:0] mod3(input logic [2:0] v);
      logic [1:0] r;
      unique case (v)
         3'd0:    r = 2'd0;
         3'd1:    r = 2'd1;
         3'd2:    r = 2'd2;
         3'd3:    r = 2'd0;
         3'd4:    r = 2'd1;
         3'd5:    r = 2'd2;
         3'd6:    r = 2'd0;
         default: r = 2'd1;
      endcase
      return r;
   endfunction

endpackage

/* rtl/mtk_req_if.sv */
// ----------------------------------------------------------------------------
// mtk_req_if: key press channel
// key code and timestamp with valid/ready
// ----------------------------------------------------------------------------
interface mtk_req_if;
   import mtk_pkg::*;

   logic              valid;
   logic              ready;
   logic [KEY_W-1:0]  key_code;
   logic [TIME_W-1:0] time_ms;

   modport source (output valid, key_code, time_ms, input ready);
   modport sink   (input valid, key_code, time_ms, output ready);
endinterface

/* rtl/mtk_rsp_if.sv */
// ----------------------------------------------------------------------------
// mtk_rsp_if: result channel
// echo or message character words with valid/ready
// ----------------------------------------------------------------------------
interface mtk_rsp_if;
   import mtk_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [CHAR_W-1:0] char_code;
   logic [LEN_W-1:0]  msg_length;
   logic              last;

   modport source (output valid, kind, char_code, msg_length, last, input ready);
   modport sink   (input valid, kind, char_code, msg_length, last, output ready);
endinterface

/* rtl/mtk_csr_if.sv */
// ----------------------------------------------------------------------------
// mtk_csr_if: register write channel
// register index and write data with valid/ready
// ----------------------------------------------------------------------------
interface mtk_csr_if;
   import mtk_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/multi_tap_keypad_text_entry.sv */
// ----------------------------------------------------------------------------
// multi_tap_keypad_text_entry: multi-tap remote keypad text entry
// echo word registered from the queue head; send words via load, store read, emit
// throughput: one press per cycle into a 2-entry queue unless full, one per cycle
// out while no send streams and the output is free; one store read per sent character
// reset: synchronous, clears control state; message store is not cleared
// ----------------------------------------------------------------------------
module multi_tap_keypad_text_entry #(
   parameter int MSG_DEPTH = mtk_pkg::MSG_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   mtk_req_if.sink   req_port,
   mtk_rsp_if.source rsp_port,
   mtk_csr_if.sink   csr_port
);
   import mtk_pkg::*;

   // front to queue
   logic      q_full;
   logic      q_push;
   press_type q_push_data;

   // queue to back
   logic      q_valid;
   logic      q_pop;
   press_type q_data;

   // front: drops presses inside the hold-off window, tags repeat timeout,
   // decodes the key; owns the timing registers and the csr port
   mtk_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_port),
      .csr_port    (csr_port),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   // short queue so intake keeps going while a send streams out
   mtk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   // back: letter cycling, commits to the message store, result words
   mtk_back #(
      .MSG_DEPTH (MSG_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_data   (q_data),
      .q_pop    (q_pop),
      .rsp_port (rsp_port)
   );

endmodule

/* rtl/mtk_front.sv */
// ----------------------------------------------------------------------------
// mtk_front: press intake
// hold-off filter, repeat timeout check, key classification, timing registers
// ----------------------------------------------------------------------------
module mtk_front (
   input  logic               clock,
   input  logic               reset,
   mtk_req_if.sink            req_port,
   mtk_csr_if.sink            csr_port,
   input  logic               q_full,
   output logic               q_push,
   output mtk_pkg::press_type q_push_data
);
   import mtk_pkg::*;

   logic [CFG_W-1:0]  holdoff_ff, holdoff_in;
   logic [CFG_W-1:0]  timeout_ff, timeout_in;
   logic [TIME_W-1:0] last_time_ff, last_time_in;
   logic [TIME_W-1:0] gap;
   logic              held_off;
   logic              accept;
   press_type         press;

   assign csr_port.ready = 1'b1;
   assign req_port.ready = !q_full;

   // modulo 2^32 gap since the last press that was not held off
   assign gap      = req_port.time_ms - last_time_ff;
   assign held_off = gap < TIME_W'(holdoff_ff);
   assign accept   = req_port.valid && req_port.ready;
   assign q_push   = accept && !held_off;

   always_comb begin
      press           = classify(req_port.key_code);
      press.timed_out = gap >= TIME_W'(timeout_ff);
   end
   assign q_push_data = press;

   always_comb begin
      holdoff_in   = holdoff_ff;
      timeout_in   = timeout_ff;
      last_time_in = last_time_ff;
      if (csr_port.valid) begin
         unique case (csr_port.index)
            CSR_HOLDOFF: holdoff_in = csr_port.data;
            CSR_TIMEOUT: timeout_in = csr_port.data;
            default:     ;
         endcase
      end
      if (q_push) begin
         last_time_in = req_port.time_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holdoff_ff   <= HOLDOFF_RST;
         timeout_ff   <= TIMEOUT_RST;
         last_time_ff <= '0;
      end else begin
         holdoff_ff   <= holdoff_in;
         timeout_ff   <= timeout_in;
         last_time_ff <= last_time_in;
      end
   end

endmodule

/* rtl/mtk_queue.sv */
// ----------------------------------------------------------------------------
// mtk_queue: short press queue
// decouples press intake from text editing
// ----------------------------------------------------------------------------
module mtk_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mtk_pkg::press_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output mtk_pkg::press_type pop_data
);
   import mtk_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   press_type        entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full      = cnt_ff == CNT_FULL;
   assign pop_valid = cnt_ff != '0;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/mtk_back.sv */
// ----------------------------------------------------------------------------
// mtk_back: text editor
// multi-tap letter state, message store, echo and send streaming
// ----------------------------------------------------------------------------
module mtk_back #(
   parameter int MSG_DEPTH = mtk_pkg::MSG_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  mtk_pkg::press_type q_data,
   output logic               q_pop,
   mtk_rsp_if.source          rsp_port
);
   import mtk_pkg::*;

   localparam int CNT_W = $clog2(MSG_DEPTH);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MSG_DEPTH - 1);

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_LOAD = 3'b010,
      B_EMIT = 3'b100
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic [KEY_W-1:0]  prev_key_ff, prev_key_in;
   logic              prev_valid_ff, prev_valid_in;
   logic signed [3:0] cyc_ff, cyc_in;
   logic [CHAR_W-1:0] pending_ff, pending_in;
   logic              caps_ff, caps_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CHAR_W-1:0] rd_data_ff;
   logic [CHAR_W-1:0] store_mem [MSG_DEPTH];

   logic              rsp_valid_ff, rsp_valid_in;
   logic              kind_ff, kind_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              last_ff, last_in;

   logic              out_free;
   logic              out_load;
   logic              wr_en;
   logic              rd_en;
   logic [CNT_W-1:0]  rd_addr;
   logic [CNT_W-1:0]  idx_nxt;

   logic              prev_send, prev_del, prev_caps;
   logic              differs, commit, do_store;
   logic signed [3:0] cyc_step, cyc_pos;
   logic [CNT_W-1:0]  count_step;
   logic [1:0]        letter_idx;
   logic [CHAR_W-1:0] letter_char;

   assign out_free = !rsp_valid_ff || rsp_port.ready;
   assign idx_nxt  = idx_ff + CNT_W'(1);

   // commit and repeat decisions for the press at the queue head
   assign prev_send  = prev_valid_ff && prev_key_ff == KEY_SEND;
   assign prev_del   = prev_valid_ff && prev_key_ff == KEY_DELETE;
   assign prev_caps  = prev_valid_ff && prev_key_ff == KEY_CAPS;
   assign differs    = !prev_valid_ff || prev_key_ff != q_data.key;
   assign commit     = (differs || q_data.timed_out) && !prev_send && !prev_del;
   assign do_store   = commit && !prev_caps && pending_ff != CHAR_NONE && count_ff < CNT_MAX;
   assign cyc_step   = commit ? 4'sd0 : ((cyc_ff < CYCLE_MAX) ? cyc_ff + 4'sd1 : cyc_ff);
   assign count_step = count_ff + CNT_W'(do_store);
   assign cyc_pos    = (cyc_step < 4'sd0) ? 4'sd0 : cyc_step;
   assign letter_idx = q_data.span4 ? cyc_pos[1:0] : mod3(cyc_pos[2:0]);
   assign letter_char = q_data.base + CHAR_W'(letter_idx) - (caps_ff ? CASE_SHIFT : CHAR_NONE);

   always_comb begin
      state_in      = state_ff;
      prev_key_in   = prev_key_ff;
      prev_valid_in = prev_valid_ff;
      cyc_in        = cyc_ff;
      pending_in    = pending_ff;
      caps_in       = caps_ff;
      count_in      = count_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;
      out_load      = 1'b0;
      kind_in       = kind_ff;
      char_in       = char_ff;
      len_in        = len_ff;
      last_in       = last_ff;

      unique case (state_ff)
         B_IDLE: begin
            if (q_valid && out_free) begin
               q_pop         = 1'b1;
               wr_en         = do_store;
               prev_key_in   = q_data.key;
               prev_valid_in = 1'b1;
               count_in      = count_step;
               cyc_in        = cyc_step;
               case (q_data.kclass)
                  KC_LETTER: begin
                     cyc_in     = $signed({2'b00, letter_idx});
                     pending_in = letter_char;
                  end
                  KC_SPACE: pending_in = CHAR_SPACE;
                  KC_CAPS: begin
                     caps_in = !caps_ff;
                     cyc_in  = cyc_step - 4'sd1;
                  end
                  KC_DELETE: begin
                     pending_in = CHAR_SPACE;
                     cyc_in     = cyc_step - 4'sd1;
                     if (count_step != '0) begin
                        count_in = count_step - CNT_W'(1);
                     end
                  end
                  KC_SEND: begin
                     count_in = '0;
                     cyc_in   = CYCLE_NONE;
                     n_in     = count_step;
                     idx_in   = '0;
                  end
                  default: ;
               endcase
               if (q_data.kclass == KC_SEND) begin
                  if (count_step == '0) begin
                     out_load = 1'b1;
                     kind_in  = 1'b1;
                     char_in  = CHAR_NONE;
                     len_in   = '0;
                     last_in  = 1'b1;
                  end else begin
                     state_in = B_LOAD;
                  end
               end else begin
                  out_load = 1'b1;
                  kind_in  = 1'b0;
                  char_in  = pending_in;
                  len_in   = LEN_W'(count_in);
                  last_in  = 1'b1;
               end
            end
         end
         B_LOAD: begin
            rd_en    = 1'b1;
            state_in = B_EMIT;
         end
         B_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               kind_in  = 1'b1;
               char_in  = rd_data_ff;
               len_in   = '0;
               last_in  = idx_nxt == n_ff;
               if (idx_nxt == n_ff) begin
                  state_in = B_IDLE;
               end else begin
                  idx_in  = idx_nxt;
                  rd_en   = 1'b1;
                  rd_addr = idx_nxt;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase

      rsp_valid_in = out_load ? 1'b1 : (rsp_port.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         prev_valid_ff <= 1'b0;
         cyc_ff        <= CYCLE_NONE;
         pending_ff    <= CHAR_NONE;
         caps_ff       <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_valid_ff <= prev_valid_in;
         cyc_ff        <= cyc_in;
         pending_ff    <= pending_in;
         caps_ff       <= caps_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_key_ff <= prev_key_in;
      n_ff        <= n_in;
      idx_ff      <= idx_in;
      if (out_load) begin
         kind_ff <= kind_in;
         char_ff <= char_in;
         len_ff  <= len_in;
         last_ff <= last_in;
      end
   end

   // message store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[count_ff] <= pending_ff;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.kind       = kind_ff;
   assign rsp_port.char_code  = char_ff;
   assign rsp_port.msg_length = len_ff;
   assign rsp_port.last       = last_ff;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("message count beyond store capacity");

   a_cycle_range: assert property (@(posedge clock) disable iff (reset)
      cyc_ff >= CYCLE_NONE)
      else $error("repeat index below minus one");

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_EMIT |-> idx_ff < n_ff)
      else $error("send index past message end");

   a_send_clears: assert property (@(posedge clock) disable iff (reset)
      q_pop && q_data.kclass == KC_SEND |=> count_ff == '0)
      else $error("send did not clear the message");

endmodule

/* tb/sv/tb_multi_tap_keypad_text_entry.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_tap_keypad_text_entry: self-checking bench for multi-tap text entry
// drives timestamped key presses, keeps its own model of the letter cycling,
// message store and send stream, and checks every result word in order;
// runs through several hold-off / repeat-timeout settings and idling mixes
// ----------------------------------------------------------------------------
module tb_multi_tap_keypad_text_entry;
   import mtk_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int QUIET_CYCLES = 16;
   localparam int LONG_HOLD    = 400;    // receiver hold-off for the back-pressure test
   localparam int STORE_MAX    = MSG_DEPTH_DEF - 1;

   // how a directed row is checked
   typedef enum logic [1:0] {
      CHK_MODEL,   // expectation from the bench model
      CHK_ECHO,    // one echo word typed into the row
      CHK_NONE,    // press falls inside the hold-off, nothing comes back
      CHK_EMPTY    // send of an empty message
   } row_check_type;

   typedef struct packed {
      logic              kind;
      logic [CHAR_W-1:0] char_code;
      logic [LEN_W-1:0]  msg_length;
      logic              last;
   } text_word_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] stamp;
      row_check_type     chk;
      logic [CHAR_W-1:0] ch;
      logic [LEN_W-1:0]  len;
   } press_row_type;

   logic clock;
   logic reset;

   mtk_req_if req_if ();
   mtk_rsp_if rsp_if ();
   mtk_csr_if csr_if ();

   multi_tap_keypad_text_entry u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   // ------------------------------------------------------------------------
   // bench copy of the keypad state and its two registers
   // ------------------------------------------------------------------------
   logic [CHAR_W-1:0] msg_mem [MSG_DEPTH_DEF];
   int                msg_cnt;
   logic [KEY_W-1:0]  prior_key;
   bit                prior_valid;
   int                tap_idx;        // signed repeat count, -1 after send
   logic [CHAR_W-1:0] pend_ch;
   bit                caps;
   logic [TIME_W-1:0] t_accept;
   logic [TIME_W-1:0] t_press;
   logic [CFG_W-1:0]  cfg_holdoff;
   logic [CFG_W-1:0]  cfg_timeout;

   text_word_type expected_words [$];   // words still owed by the block, oldest first
   text_word_type fresh_words [$];      // words caused by the press just accepted

   // knobs shared between the stimulus and the receiver process
   int unsigned src_idle_pct;
   int unsigned snk_stall_pct;
   bit          long_hold_req;

   int               mismatch_count;
   int               cycle_count;
   logic [TIME_W-1:0] stamp_ms;      // free-running press clock of the sender
   logic [KEY_W-1:0]  last_key_sent;

   logic [KEY_W-1:0] letter_keys [8] = '{KEY_ABC, KEY_DEF, KEY_GHI, KEY_JKL,
                                         KEY_MNO, KEY_PQRS, KEY_TUV, KEY_WXYZ};

   // directed presses at the reset settings (hold-off 200, repeat timeout 1500)
   press_row_type dir_rows [0:24] = '{
      // hold-off is measured from time zero right after reset
      '{KEY_ABC,    32'd0,          CHK_NONE,  8'h00, 6'd0},
      '{KEY_ABC,    32'd100,        CHK_NONE,  8'h00, 6'd0},
      // first letter, then cycling a-b-c and wrapping back to a
      '{KEY_ABC,    32'd1000,       CHK_ECHO,  "a",   6'd0},
      '{KEY_ABC,    32'd1300,       CHK_ECHO,  "b",   6'd0},
      '{KEY_ABC,    32'd1600,       CHK_ECHO,  "c",   6'd0},
      '{KEY_ABC,    32'd1900,       CHK_ECHO,  "a",   6'd0},
      '{KEY_ABC,    32'd2000,       CHK_NONE,  8'h00, 6'd0},
      // new key commits the pending letter, four-letter key wraps after s
      '{KEY_PQRS,   32'd2200,       CHK_ECHO,  "p",   6'd1},
      '{KEY_PQRS,   32'd2400,       CHK_ECHO,  "q",   6'd1},
      '{KEY_PQRS,   32'd2600,       CHK_ECHO,  "r",   6'd1},
      '{KEY_PQRS,   32'd2800,       CHK_ECHO,  "s",   6'd1},
      '{KEY_PQRS,   32'd3000,       CHK_ECHO,  "p",   6'd1},
      '{KEY_SPACE,  32'd3200,       CHK_ECHO,  " ",   6'd2},
      '{KEY_SPACE,  32'd3400,       CHK_ECHO,  " ",   6'd2},
      // caps lock echoes the pending blank and stores nothing on the next key
      '{KEY_CAPS,   32'd3600,       CHK_ECHO,  " ",   6'd3},
      '{KEY_DEF,    32'd3800,       CHK_ECHO,  "D",   6'd3},
      '{KEY_DEF,    32'd4000,       CHK_ECHO,  "E",   6'd3},
      // same key after the repeat timeout starts a new letter
      '{KEY_DEF,    32'd6000,       CHK_ECHO,  "D",   6'd4},
      '{KEY_DELETE, 32'd6200,       CHK_ECHO,  " ",   6'd4},
      '{KEY_DELETE, 32'd6400,       CHK_ECHO,  " ",   6'd3},
      // send streams three characters, a second send finds the store empty
      '{KEY_SEND,   32'd6600,       CHK_MODEL, 8'h00, 6'd0},
      '{KEY_SEND,   32'd6800,       CHK_EMPTY, 8'h00, 6'd0},
      // unknown keys echo the pending letter; timestamp wraps at the end
      '{12'h000,    32'd7000,       CHK_ECHO,  " ",   6'd0},
      '{12'hFFF,    32'hFFFF_FFFF,  CHK_ECHO,  " ",   6'd1},
      '{12'hFFF,    32'h0000_0063,  CHK_NONE,  8'h00, 6'd0}
   };

   // ------------------------------------------------------------------------
   // clock
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one line for each of the first 40 mismatches, the count decides the final verdict
   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("[%0t] mismatch: %s", $time, what);
      end
   endtask

   task automatic reset_model();
      msg_cnt     = 0;
      prior_key   = '0;
      prior_valid = 1'b0;
      tap_idx     = int'(CYCLE_NONE);
      pend_ch     = CHAR_NONE;
      caps        = 1'b0;
      t_accept    = '0;
      t_press     = '0;
      cfg_holdoff = HOLDOFF_RST;
      cfg_timeout = TIMEOUT_RST;
   endtask

   // ------------------------------------------------------------------------
   // keypad model: one accepted press in, the words it causes into
   // fresh_words; returns their number, zero for a held-off press
   // ------------------------------------------------------------------------
   function automatic int predict_keypress(input logic [KEY_W-1:0] key,
                                           input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] since_accept;
      logic [TIME_W-1:0] since_press;
      logic [CHAR_W-1:0] base;
      int                span;
      bit                differs;
      bit                timed_out;
      bit                from_send;
      bit                from_del;
      bit                from_caps;
      int                n;
      int                i;

      fresh_words.delete();
      since_accept = now - t_accept;
      if (since_accept < {16'd0, cfg_holdoff}) begin
         return 0;
      end
      t_accept    = now;
      since_press = now - t_press;
      timed_out   = since_press >= {16'd0, cfg_timeout};
      from_send   = prior_valid && prior_key == KEY_SEND;
      from_del    = prior_valid && prior_key == KEY_DELETE;
      from_caps   = prior_valid && prior_key == KEY_CAPS;
      differs     = !prior_valid || prior_key != key;

      // on a new key or a timed-out repeat, commit the pending letter unless the last key was send or delete
      if ((differs || timed_out) && !from_send && !from_del) begin
         if (!from_caps && pend_ch != CHAR_NONE && msg_cnt < STORE_MAX) begin
            msg_mem[msg_cnt] = pend_ch;
            msg_cnt++;
         end
         tap_idx = 0;
      end else if (tap_idx < int'(CYCLE_MAX)) begin
         tap_idx++;
      end
      t_press = now;

      span = 0;
      base = CHAR_NONE;
      case (key)
         KEY_ABC:  begin base = "a"; span = 3; end
         KEY_DEF:  begin base = "d"; span = 3; end
         KEY_GHI:  begin base = "g"; span = 3; end
         KEY_JKL:  begin base = "j"; span = 3; end
         KEY_MNO:  begin base = "m"; span = 3; end
         KEY_PQRS: begin base = "p"; span = 4; end
         KEY_TUV:  begin base = "t"; span = 3; end
         KEY_WXYZ: begin base = "w"; span = 4; end
         default:  span = 0;
      endcase

      if (span != 0) begin
         if (tap_idx < 0) begin
            tap_idx = 0;
         end
         tap_idx = tap_idx % span;
         pend_ch = base + CHAR_W'(tap_idx) - (caps ? CASE_SHIFT : 8'd0);
      end else if (key == KEY_SPACE) begin
         pend_ch = CHAR_SPACE;
      end else if (key == KEY_CAPS) begin
         caps = !caps;
         tap_idx--;
      end else if (key == KEY_DELETE) begin
         pend_ch = CHAR_SPACE;
         tap_idx--;
         if (msg_cnt > 0) begin
            msg_cnt--;
         end
      end else if (key == KEY_SEND) begin
         n           = msg_cnt;
         msg_cnt     = 0;
         tap_idx     = int'(CYCLE_NONE);
         prior_key   = key;
         prior_valid = 1'b1;
         if (n == 0) begin
            fresh_words.push_back('{1'b1, CHAR_NONE, 6'd0, 1'b1});
         end
         for (i = 0; i < n; i++) begin
            fresh_words.push_back('{1'b1, msg_mem[i], 6'd0, i == n - 1});
         end
         return fresh_words.size();
      end
      prior_key   = key;
      prior_valid = 1'b1;
      fresh_words.push_back('{1'b0, pend_ch, LEN_W'(msg_cnt), 1'b1});
      return 1;
   endfunction

   // ------------------------------------------------------------------------
   // press sender: random idle gaps, then hold the word until it is taken;
   // valid is left high so a following word goes out back to back
   // ------------------------------------------------------------------------
   task automatic offer_press(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] stamp);
      while ($urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.key_code <= key;
      req_if.time_ms  <= stamp;
      do @(posedge clock); while (!req_if.ready);
      last_key_sent = key;
   endtask

   // send one press and queue whatever the model says it causes
   task automatic press_and_predict(input logic [KEY_W-1:0] key, output int n_words);
      offer_press(key, stamp_ms);
      n_words = predict_keypress(key, stamp_ms);
      foreach (fresh_words[i]) expected_words.push_back(fresh_words[i]);
   endtask

   // register write; valid stays high for a write that follows at once
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         CSR_HOLDOFF: cfg_holdoff = value;
         CSR_TIMEOUT: cfg_timeout = value;
         default: ;
      endcase
   endtask

   // drain everything owed, let a held-off press die out, then reprogram
   task automatic apply_settings(input logic [CFG_W-1:0] holdoff,
                                 input logic [CFG_W-1:0] timeout);
      req_if.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      write_reg(CSR_HOLDOFF, holdoff);
      write_reg(CSR_TIMEOUT, timeout);
      csr_if.valid <= 1'b0;
   endtask

   // time to the next press: held off, quick repeat, slow press or a wild jump
   function automatic logic [TIME_W-1:0] next_gap();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         return $urandom;
      end
      if (pick < 18 && cfg_holdoff != 0) begin
         return $urandom_range(cfg_holdoff - 1, 0);
      end
      if (pick < 60 && cfg_timeout > cfg_holdoff) begin
         return $urandom_range(cfg_timeout - 1, cfg_holdoff);
      end
      return cfg_holdoff + cfg_timeout + $urandom_range(3000);
   endfunction

   // mostly letters typed as words, with the odd edit key and line noise
   function automatic logic [KEY_W-1:0] pick_key();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 30 && last_key_sent inside {letter_keys}) return last_key_sent;
      if (pick < 62) return letter_keys[$urandom_range(7)];
      if (pick < 70) return KEY_SPACE;
      if (pick < 77) return KEY_CAPS;
      if (pick < 84) return KEY_DELETE;
      if (pick < 90) return KEY_SEND;
      return KEY_W'($urandom_range(4095));
   endfunction

   // random presses until n_items of them were not held off
   task automatic run_random(input int n_items);
      int done;
      int n_words;
      done = 0;
      while (done < n_items) begin
         stamp_ms = stamp_ms + next_gap();
         press_and_predict(pick_key(), n_words);
         if (n_words != 0) begin
            done++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // result receiver: random stalls, plus one long hold-off on request,
   // counted down here so the sender keeps pushing into a full block
   // ------------------------------------------------------------------------
   initial begin : rsp_ready_drive
      int hold_left;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
         end
      end
   end

   // every taken word is matched against the oldest owed word
   always @(posedge clock) begin : rsp_check
      text_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("word kind %0d char %h len %0d with nothing owed",
                                      rsp_if.kind, rsp_if.char_code, rsp_if.msg_length));
         end else begin
            want = expected_words.pop_front();
            if (rsp_if.kind !== want.kind)
               report_mismatch($sformatf("kind %0d, want %0d", rsp_if.kind, want.kind));
            if (rsp_if.char_code !== want.char_code)
               report_mismatch($sformatf("char_code %h, want %h",
                                         rsp_if.char_code, want.char_code));
            if (rsp_if.msg_length !== want.msg_length)
               report_mismatch($sformatf("msg_length %0d, want %0d",
                                         rsp_if.msg_length, want.msg_length));
            if (rsp_if.last !== want.last)
               report_mismatch($sformatf("last %0d, want %0d", rsp_if.last, want.last));
         end
      end
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int n_words;
      int i;

      mismatch_count  = 0;
      cycle_count     = 0;
      src_idle_pct    = 0;
      snk_stall_pct   = 0;
      long_hold_req   = 1'b0;
      stamp_ms        = '0;
      last_key_sent   = '0;
      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.key_code <= '0;
      req_if.time_ms  <= '0;
      csr_if.valid    <= 1'b0;
      csr_if.index    <= '0;
      csr_if.data     <= '0;
      reset_model();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed rows, typed expectations where they are plain to see
      foreach (dir_rows[r]) begin
         offer_press(dir_rows[r].key, dir_rows[r].stamp);
         void'(predict_keypress(dir_rows[r].key, dir_rows[r].stamp));
         case (dir_rows[r].chk)
            CHK_MODEL: foreach (fresh_words[k]) expected_words.push_back(fresh_words[k]);
            CHK_ECHO:  expected_words.push_back('{1'b0, dir_rows[r].ch, dir_rows[r].len, 1'b1});
            CHK_EMPTY: expected_words.push_back('{1'b1, CHAR_NONE, 6'd0, 1'b1});
            default: ;
         endcase
         stamp_ms = dir_rows[r].stamp;
      end

      // no hold-off, longest repeat timeout, no idling on either side
      apply_settings(16'd0, 16'hFFFF);
      run_random(12);

      // longest hold-off with immediate timeout, sender idles
      src_idle_pct = 48;
      apply_settings(16'hFFFF, 16'd0);
      run_random(12);

      // every press commits: fill the store past full, then send it while
      // the receiver holds off so the block backs up into the sender
      src_idle_pct  = 0;
      snk_stall_pct = 48;
      apply_settings(16'd0, 16'd0);
      for (i = 0; i < STORE_MAX + 3; i++) begin
         stamp_ms = stamp_ms + $urandom_range(3000);
         press_and_predict(letter_keys[$urandom_range(7)], n_words);
      end
      long_hold_req = 1'b1;
      stamp_ms = stamp_ms + 32'd500;
      press_and_predict(KEY_SEND, n_words);
      run_random(8);

      // mid-range settings, both sides idle now and then
      src_idle_pct  = 25;
      snk_stall_pct = 25;
      apply_settings(16'($urandom_range(400, 50)), 16'($urandom_range(2000, 600)));
      run_random(12);

      // back to the reset settings with a slow receiver
      src_idle_pct  = 0;
      snk_stall_pct = 48;
      apply_settings(HOLDOFF_RST, TIMEOUT_RST);
      run_random(12);

      // let the block finish everything it owes
      req_if.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
